// ===== sv/apid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apid_pkg: shared types and constants of the angle PID position loop
// Holds the gain width, the config register indexes, the request kinds and
// the gain bundle passed from the register bank to the datapath.
// ----------------------------------------------------------------------------
package apid_pkg;

  // Gains are unsigned fixed point with fractional bits set on the top level
  localparam int GainW = 24;
  // Widest config register
  localparam int CfgW  = 24;
  localparam int CfgAddrW = 2;

  // Drive and offset-binary code widths
  localparam int DriveW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_KP     = 2'd0,
    CFG_KD     = 2'd1,
    CFG_KI     = 2'd2,
    CFG_TARGET = 2'd3
  } cfg_addr_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [GainW-1:0] prop;
    logic [GainW-1:0] deriv;
    logic [GainW-1:0] integ;
  } gains_t;

endpackage

// ===== sv/apid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apid_core: PID datapath and loop state
// Wraps the angle error, forms the P, D and I terms with the P term clamped,
// saturates the drive sum and truncates it toward zero. Holds the previous error and the
// clamped integrator, updated once per request that moves to the output.
// ----------------------------------------------------------------------------
module apid_core #(
  parameter int ANGLE_BITS     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  apid_pkg::kind_e               kind_i,
  input  logic [ANGLE_BITS-1:0]         angle_i,
  input  logic [ANGLE_BITS-1:0]         target_i,
  input  apid_pkg::gains_t              gains_i,
  output logic signed [apid_pkg::DriveW-1:0] drive_o,
  output logic                          sat_o
);
  import apid_pkg::*;

  localparam int A     = ANGLE_BITS;
  localparam int F     = GAIN_FRAC_BITS;
  localparam int PW    = GainW + 1 + A;      // P and I products
  localparam int DW    = GainW + 2 + A;      // D product
  localparam int SUM_W = GainW + A + 4;
  localparam int I_W   = F + 7;              // integrator holds [-64,63] scaled

  localparam logic signed [SUM_W-1:0] P_HI   = SUM_W'(511 * (2 ** F));
  localparam logic signed [SUM_W-1:0] P_LO   = -SUM_W'(512 * (2 ** F));
  localparam logic signed [SUM_W-1:0] I_HI   = SUM_W'(63 * (2 ** F));
  localparam logic signed [SUM_W-1:0] I_LO   = -SUM_W'(64 * (2 ** F));
  localparam logic signed [SUM_W-1:0] S_HI   = SUM_W'(111 * (2 ** F));
  localparam logic signed [SUM_W-1:0] S_LO   = -SUM_W'(112 * (2 ** F));
  localparam logic signed [SUM_W-1:0] FRAC_M = SUM_W'((2 ** F) - 1);
  localparam logic signed [I_W-1:0]   I_HI_S = I_W'(63 * (2 ** F));
  localparam logic signed [I_W-1:0]   I_LO_S = -I_W'(64 * (2 ** F));

  logic signed [A-1:0]     prev_err_q, prev_err_d, prev_use;
  logic signed [I_W-1:0]   integ_q, integ_d, integ_use;
  logic signed [A-1:0]     err;
  logic signed [A:0]       derr;
  logic signed [PW-1:0]    p_prod, inc_prod;
  logic signed [DW-1:0]    d_prod;
  logic signed [SUM_W-1:0] p_ext, p_cl, d_ext, inc_ext, integ_ext;
  logic signed [SUM_W-1:0] integ_sum, integ_cl, sum, sum_cl, sum_adj, quot;
  logic                    is_stop, is_start, sum_hit;

  assign is_start = (kind_i == KIND_START);
  assign is_stop  = !((kind_i == KIND_SAMPLE) || is_start);

  // Wrap the error to half a turn by modular subtraction
  assign err = signed'(target_i - angle_i);

  // Prime history and clear the integrator at the start of a move
  assign prev_use  = is_start ? err : prev_err_q;
  assign integ_use = is_start ? '0 : integ_q;
  assign derr      = {err[A-1], err} - {prev_use[A-1], prev_use};

  // Three independent gain products
  assign p_prod   = $signed({1'b0, gains_i.prop}) * err;
  assign d_prod   = $signed({1'b0, gains_i.deriv}) * derr;
  assign inc_prod = $signed({1'b0, gains_i.integ}) * err;

  assign p_ext     = {{(SUM_W-PW){p_prod[PW-1]}}, p_prod};
  assign d_ext     = {{(SUM_W-DW){d_prod[DW-1]}}, d_prod};
  assign inc_ext   = {{(SUM_W-PW){inc_prod[PW-1]}}, inc_prod};
  assign integ_ext = {{(SUM_W-I_W){integ_use[I_W-1]}}, integ_use};

  // Clamp the proportional term
  always_comb begin
    if (p_ext > P_HI) begin
      p_cl = P_HI;
    end else if (p_ext < P_LO) begin
      p_cl = P_LO;
    end else begin
      p_cl = p_ext;
    end
  end

  assign sum       = p_cl + d_ext + inc_ext + integ_ext;
  assign integ_sum = integ_ext + inc_ext;

  // Saturate the integrator
  always_comb begin
    if (integ_sum > I_HI) begin
      integ_cl = I_HI;
    end else if (integ_sum < I_LO) begin
      integ_cl = I_LO;
    end else begin
      integ_cl = integ_sum;
    end
  end

  // Saturate the drive sum and flag the clamp
  always_comb begin
    sum_hit = 1'b1;
    if (sum > S_HI) begin
      sum_cl = S_HI;
    end else if (sum < S_LO) begin
      sum_cl = S_LO;
    end else begin
      sum_cl  = sum;
      sum_hit = 1'b0;
    end
  end

  // Truncate toward zero: bias negative values before the shift
  assign sum_adj = sum_cl + (sum_cl[SUM_W-1] ? FRAC_M : '0);
  assign quot    = sum_adj >>> F;

  assign drive_o = is_stop ? '0 : quot[DriveW-1:0];
  assign sat_o   = is_stop ? 1'b0 : sum_hit;

  // Next loop state
  always_comb begin
    prev_err_d = prev_err_q;
    integ_d    = integ_q;
    if (step_i) begin
      if (is_stop) begin
        prev_err_d = '0;
        integ_d    = '0;
      end else begin
        prev_err_d = err;
        integ_d    = integ_cl[I_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
    end else begin
      prev_err_q <= prev_err_d;
      integ_q    <= integ_d;
    end
  end

  // Integrator never leaves its clamp window
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= I_HI_S) && (integ_q >= I_LO_S))
    else $error("integrator outside clamp window");

  // A stop request leaves cleared loop state
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_stop) |=> (integ_q == '0) && (prev_err_q == '0))
    else $error("loop state not cleared by stop");

  // A saturated drive sits at one of the limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_o |-> (drive_o == 8'sd111) || (drive_o == -8'sd112))
    else $error("saturated drive not at a limit");

endmodule

// ===== sv/angle_pid_position_loop_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_pid_position_loop_top: PID position loop for a shaft angle
// Takes one measured angle per request and returns one motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the request kind (sample, start, stop),
//   tdata the measured angle in counts. Master stream: tdata carries the
//   signed drive and its offset-binary motor code, tuser the saturation flag.
//   Gains and target are set through the write port while the loop is idle.
// Pipeline and throughput:
//   A request is captured in the input register, passes the PID datapath
//   (one multiplier level plus add and clamp) and lands in the result
//   register, which drives tvalid. One request per cycle is taken while
//   the master side takes results.
// Reset:
//   Clears both registers' valid flags, the previous error and the integrator,
//   and loads the default gains and target.
// Stall:
//   When the master holds tready low the result holds, one more request waits
//   in the input register, and tready on the slave side then drops.
// ----------------------------------------------------------------------------
module angle_pid_position_loop_top #(
  parameter int ANGLE_BITS     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [apid_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [apid_pkg::CfgW-1:0]         cfg_wdata_i,
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((ANGLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // measured_angle
  input  logic [1:0]                        s_axis_tuser,  // kind
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // drive, motor_code
  output logic                              m_axis_tuser   // output_saturated
);
  import apid_pkg::*;

  localparam int A = ANGLE_BITS;

  gains_t                    gains_q;
  logic [A-1:0]              target_q;
  logic                      in_valid_q, out_valid_q;
  kind_e                     kind_q;
  logic [A-1:0]              angle_q;
  logic signed [DriveW-1:0]  drive_q, drive;
  logic                      sat_q, sat;
  logic                      advance, move;

  // Config register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= GainW'(8960);
      gains_q.deriv <= GainW'(81920);
      gains_q.integ <= GainW'(160);
      target_q      <= A'(16384);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_e'(cfg_addr_i))
        CFG_KP:     gains_q.prop  <= cfg_wdata_i[GainW-1:0];
        CFG_KD:     gains_q.deriv <= cfg_wdata_i[GainW-1:0];
        CFG_KI:     gains_q.integ <= cfg_wdata_i[GainW-1:0];
        CFG_TARGET: target_q      <= cfg_wdata_i[A-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance       = !out_valid_q || m_axis_tready;
  assign move          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= kind_e'(s_axis_tuser);
      angle_q <= s_axis_tdata[A-1:0];
    end
  end

  apid_core #(
    .ANGLE_BITS     (ANGLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (move),
    .kind_i   (kind_q),
    .angle_i  (angle_q),
    .target_i (target_q),
    .gains_i  (gains_q),
    .drive_o  (drive),
    .sat_o    (sat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      drive_q <= drive;
      sat_q   <= sat;
    end
  end

  // Offset binary: adding 128 flips the sign bit
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {~drive_q[DriveW-1], drive_q[DriveW-2:0], drive_q};
  assign m_axis_tuser  = sat_q;

  // A request waiting behind a stalled result is kept
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("queued request lost during stall");

  // A request that moves always shows up as a result
  a_move_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("moved request produced no result");

  // Motor code top bit is the inverse of the drive sign bit
  a_code_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata[15] != m_axis_tdata[7]))
    else $error("motor code does not match drive");

endmodule
